/* sv/tcw_pkg.sv */
`default_nettype none
package tcw_pkg;

    localparam logic [7:0] CHAR_NEWLINE   = 8'h0a;
    localparam logic [7:0] CHAR_RETURN    = 8'h0d;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;

    localparam logic [3:0] FG_RESET = 4'h3;
    localparam logic [3:0] BG_RESET = 4'h9;

    localparam logic [1:0] CFG_FG     = 2'd0;
    localparam logic [1:0] CFG_BG     = 2'd1;
    localparam logic [1:0] CFG_ACTIVE = 2'd2;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] KIND_SET    = 2'd0;
    localparam logic [1:0] KIND_SCROLL = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    typedef enum logic [1:0] {
        W_SPACE_CUR,
        W_CHAR_CUR,
        W_ZERO,
        W_SPACE_CLR
    } wsel_t;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_ZERO,
        CUR_INC,
        CUR_DEC
    } cur_op_t;

    typedef enum logic [2:0] {
        COL_HOLD,
        COL_CURSOR,
        COL_CURSOR_DEC,
        COL_ZERO,
        COL_INC
    } col_op_t;

    typedef struct packed {
        logic       accept;
        col_op_t    col_op;
        cur_op_t    cur_op;
        logic       mem_we;
        wsel_t      wsel;
        logic       base_inc;
        logic       clr_start;
        logic       emit;
        logic [1:0] kind;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       is_newline;
        logic       is_backspace;
        logic       cursor_zero;
        logic       cursor_last;
        logic       col_last;
        logic       active;
        logic       out_free;
    } sts_t;

    localparam cmd_t CMD_NOP = '{
        accept:    1'b0,
        col_op:    COL_HOLD,
        cur_op:    CUR_HOLD,
        mem_we:    1'b0,
        wsel:      W_ZERO,
        base_inc:  1'b0,
        clr_start: 1'b0,
        emit:      1'b0,
        kind:      KIND_SET,
        last:      1'b0
    };

endpackage
`default_nettype wire

/* sv/tcw_datapath.sv */
`default_nettype none
module tcw_datapath #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire tcw_pkg::cmd_t cmd,
    output tcw_pkg::sts_t      sts,
    input  wire logic [1:0]    in_op,
    input  wire logic [7:0]    in_char,
    input  wire logic [4:0]    in_row,
    input  wire logic [4:0]    in_col,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [3:0]    cfg_data,
    input  wire logic          out_ready,
    output logic               out_valid,
    output logic [1:0]         out_kind,
    output logic [4:0]         out_row,
    output logic [4:0]         out_col,
    output logic [7:0]         out_char,
    output logic [7:0]         out_attr,
    output logic               out_last
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);

    logic [15:0] mem [DEPTH];

    logic [3:0]      fg_reg, bg_reg;
    logic            active_reg;
    logic [RW-1:0]   base_reg;
    logic [CW-1:0]   cursor_reg;
    logic [CW-1:0]   col_reg;
    logic [7:0]      clr_attr_reg;
    logic [ROWS-1:0] blank_reg;
    logic [1:0]      op_reg;
    logic [7:0]      char_reg;
    logic [4:0]      row_reg;
    logic [4:0]      colin_reg;
    logic [15:0]     rd_word_reg;

    logic            out_valid_reg;
    logic [1:0]      out_kind_reg;
    logic [4:0]      out_row_reg, out_col_reg;
    logic [7:0]      out_char_reg, out_attr_reg;
    logic            out_last_reg;

    logic [7:0]      cur_attr;
    logic [6:0]      rd_sum;
    logic [RW-1:0]   rd_phys;
    logic [AW-1:0]   rd_addr, wr_addr;
    logic [RW-1:0]   bot_row;
    logic [15:0]     wdata;
    logic            in_range;
    logic [7:0]      rd_char, rd_attr;
    logic            out_free;

    assign cur_attr = {bg_reg, fg_reg};
    assign out_free = !out_valid_reg || out_ready;

    assign rd_sum  = 7'(row_reg) + 7'(base_reg);
    assign rd_phys = (rd_sum >= 7'(ROWS)) ? RW'(rd_sum - 7'(ROWS)) : RW'(rd_sum);
    assign rd_addr = AW'(rd_phys) * AW'(COLUMNS) + AW'(colin_reg);
    assign bot_row = (base_reg == '0) ? RW'(ROWS - 1) : base_reg - 1'b1;
    assign wr_addr = AW'(bot_row) * AW'(COLUMNS) + AW'(col_reg);

    assign in_range = (7'(row_reg) < 7'(ROWS)) && (6'(colin_reg) < 6'(COLUMNS));

    always_comb begin
        if (!in_range) begin
            rd_char = 8'h00;
            rd_attr = 8'h00;
        end else if (blank_reg[rd_phys]) begin
            rd_char = tcw_pkg::CHAR_SPACE;
            rd_attr = clr_attr_reg;
        end else begin
            rd_char = rd_word_reg[15:8];
            rd_attr = rd_word_reg[7:0];
        end
    end

    always_comb begin
        case (cmd.wsel)
            tcw_pkg::W_SPACE_CUR: wdata = {tcw_pkg::CHAR_SPACE, cur_attr};
            tcw_pkg::W_CHAR_CUR:  wdata = {char_reg, cur_attr};
            tcw_pkg::W_ZERO:      wdata = 16'h0000;
            default:              wdata = {tcw_pkg::CHAR_SPACE, clr_attr_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            mem[wr_addr] <= wdata;
        end
        rd_word_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg    <= in_op;
            char_reg  <= in_char;
            row_reg   <= in_row;
            colin_reg <= in_col;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg       <= tcw_pkg::FG_RESET;
            bg_reg       <= tcw_pkg::BG_RESET;
            active_reg   <= 1'b0;
            base_reg     <= '0;
            cursor_reg   <= '0;
            col_reg      <= '0;
            clr_attr_reg <= 8'h00;
            blank_reg    <= '1;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    tcw_pkg::CFG_FG:     fg_reg <= cfg_data;
                    tcw_pkg::CFG_BG:     bg_reg <= cfg_data;
                    tcw_pkg::CFG_ACTIVE: active_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            if (cmd.base_inc) begin
                base_reg <= (base_reg == RW'(ROWS - 1)) ? '0 : base_reg + 1'b1;
            end

            case (cmd.cur_op)
                tcw_pkg::CUR_ZERO: cursor_reg <= '0;
                tcw_pkg::CUR_INC:  cursor_reg <= cursor_reg + 1'b1;
                tcw_pkg::CUR_DEC:  cursor_reg <= cursor_reg - 1'b1;
                default: ;
            endcase

            case (cmd.col_op)
                tcw_pkg::COL_CURSOR:     col_reg <= cursor_reg;
                tcw_pkg::COL_CURSOR_DEC: col_reg <= cursor_reg - 1'b1;
                tcw_pkg::COL_ZERO:       col_reg <= '0;
                tcw_pkg::COL_INC:        col_reg <= col_reg + 1'b1;
                default: ;
            endcase

            // A blank row reads as spaces in the attribute of the last clear.
            if (cmd.clr_start) begin
                clr_attr_reg <= cur_attr;
                blank_reg    <= '1;
            end else if (cmd.mem_we) begin
                blank_reg[bot_row] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_kind_reg <= cmd.kind;
            out_last_reg <= cmd.last;
            case (cmd.kind)
                tcw_pkg::KIND_SET: begin
                    out_row_reg  <= 5'(ROWS - 1);
                    out_col_reg  <= 5'(col_reg);
                    out_char_reg <= wdata[15:8];
                    out_attr_reg <= wdata[7:0];
                end
                tcw_pkg::KIND_READ: begin
                    out_row_reg  <= row_reg;
                    out_col_reg  <= colin_reg;
                    out_char_reg <= rd_char;
                    out_attr_reg <= rd_attr;
                end
                default: begin
                    out_row_reg  <= 5'd0;
                    out_col_reg  <= 5'd0;
                    out_char_reg <= 8'h00;
                    out_attr_reg <= cur_attr;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_char  = out_char_reg;
    assign out_attr  = out_attr_reg;
    assign out_last  = out_last_reg;

    assign sts.op           = op_reg;
    assign sts.is_newline   = (char_reg == tcw_pkg::CHAR_NEWLINE)
                              || (char_reg == tcw_pkg::CHAR_RETURN);
    assign sts.is_backspace = (char_reg == tcw_pkg::CHAR_BACKSPACE);
    assign sts.cursor_zero  = (cursor_reg == '0);
    assign sts.cursor_last  = (cursor_reg == CW'(COLUMNS - 1));
    assign sts.col_last     = (col_reg == CW'(COLUMNS - 1));
    assign sts.active       = active_reg;
    assign sts.out_free     = out_free;

endmodule
`default_nettype wire

/* sv/tcw_controller.sv */
`default_nettype none
module tcw_controller (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire tcw_pkg::sts_t sts,
    output tcw_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_FILL,
        S_PUT,
        S_PUT_BS,
        S_SCROLL_START,
        S_SCROLL_SWEEP,
        S_SCROLL_EMIT,
        S_CLR_SWEEP,
        S_CLR_EMIT,
        S_READ_WAIT,
        S_READ_EMIT
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = tcw_pkg::CMD_NOP;
        unique case (state_reg)
            S_INIT: begin
                cmd.mem_we = 1'b1;
                cmd.wsel   = tcw_pkg::W_SPACE_CLR;
                cmd.col_op = tcw_pkg::COL_INC;
                if (sts.col_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (sts.op == tcw_pkg::OP_WRITE) begin
                    if (sts.is_newline) begin
                        cmd.col_op = tcw_pkg::COL_CURSOR;
                        state_next = S_FILL;
                    end else if (sts.is_backspace) begin
                        if (sts.cursor_zero) begin
                            state_next = S_IDLE;
                        end else begin
                            cmd.col_op = tcw_pkg::COL_CURSOR_DEC;
                            cmd.cur_op = tcw_pkg::CUR_DEC;
                            state_next = S_PUT_BS;
                        end
                    end else begin
                        cmd.col_op = tcw_pkg::COL_CURSOR;
                        state_next = S_PUT;
                    end
                end else if (sts.op == tcw_pkg::OP_CLEAR) begin
                    cmd.clr_start = 1'b1;
                    cmd.col_op    = tcw_pkg::COL_ZERO;
                    state_next    = S_CLR_SWEEP;
                end else if (sts.op == tcw_pkg::OP_READ) begin
                    state_next = S_READ_WAIT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_FILL: begin
                if (sts.out_free) begin
                    cmd.mem_we = 1'b1;
                    cmd.wsel   = tcw_pkg::W_SPACE_CUR;
                    cmd.emit   = sts.active;
                    cmd.kind   = tcw_pkg::KIND_SET;
                    cmd.col_op = tcw_pkg::COL_INC;
                    if (sts.col_last) begin
                        state_next = S_SCROLL_START;
                    end
                end
            end
            S_PUT: begin
                if (sts.out_free) begin
                    cmd.mem_we = 1'b1;
                    cmd.wsel   = tcw_pkg::W_CHAR_CUR;
                    cmd.emit   = sts.active;
                    cmd.kind   = tcw_pkg::KIND_SET;
                    cmd.last   = !sts.cursor_last;
                    if (sts.cursor_last) begin
                        state_next = S_SCROLL_START;
                    end else begin
                        cmd.cur_op = tcw_pkg::CUR_INC;
                        state_next = S_IDLE;
                    end
                end
            end
            S_PUT_BS: begin
                if (sts.out_free) begin
                    cmd.mem_we = 1'b1;
                    cmd.wsel   = tcw_pkg::W_SPACE_CUR;
                    cmd.emit   = sts.active;
                    cmd.kind   = tcw_pkg::KIND_SET;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCROLL_START: begin
                cmd.base_inc = 1'b1;
                cmd.col_op   = tcw_pkg::COL_ZERO;
                cmd.cur_op   = tcw_pkg::CUR_ZERO;
                state_next   = S_SCROLL_SWEEP;
            end
            S_SCROLL_SWEEP: begin
                cmd.mem_we = 1'b1;
                cmd.wsel   = tcw_pkg::W_ZERO;
                cmd.col_op = tcw_pkg::COL_INC;
                if (sts.col_last) begin
                    state_next = S_SCROLL_EMIT;
                end
            end
            S_SCROLL_EMIT: begin
                if (!sts.active) begin
                    state_next = S_IDLE;
                end else if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = tcw_pkg::KIND_SCROLL;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CLR_SWEEP: begin
                cmd.mem_we = 1'b1;
                cmd.wsel   = tcw_pkg::W_SPACE_CLR;
                cmd.col_op = tcw_pkg::COL_INC;
                if (sts.col_last) begin
                    state_next = S_CLR_EMIT;
                end
            end
            S_CLR_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = tcw_pkg::KIND_CLEAR;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ_WAIT: begin
                state_next = S_READ_EMIT;
            end
            S_READ_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = tcw_pkg::KIND_READ;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* sv/text_console_writer_top.sv */
`default_nettype none
// Text console of ROWS x COLUMNS character/attribute cells with the cursor on the
// bottom row. One transaction is taken at a time. A newline fills the rest of the
// row, and a newline or a write that reaches the row end zeroes the row that
// scrolls in; the cell memory, which has one write port, is swept one cell per
// cycle for both, the fill stalling while the output is not free. Scrolling
// rotates a row base pointer and a clear marks every row blank, so neither
// copies the whole screen. After reset the bottom row is initialized before the
// first input transaction is accepted; configuration writes are taken at any time.
module text_console_writer_top #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // char_code, cell_row, cell_column, zero pad
    input  wire logic [1:0]  s_tuser,   // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // out_row, out_column, out_char, out_attribute, pad
    output logic [1:0]       m_tuser,   // command_kind
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [3:0]  cfg_data
);

    tcw_pkg::cmd_t cmd;
    tcw_pkg::sts_t sts;
    logic [4:0]    out_row, out_col;
    logic [7:0]    out_char, out_attr;

    assign cfg_ready = 1'b1;

    tcw_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcw_datapath #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_op     (s_tuser),
        .in_char   (s_tdata[7:0]),
        .in_row    (s_tdata[12:8]),
        .in_col    (s_tdata[17:13]),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_kind  (m_tuser),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_char  (out_char),
        .out_attr  (out_attr),
        .out_last  (m_tlast)
    );

    assign m_tdata = {6'd0, out_attr, out_char, out_col, out_row};

endmodule
`default_nettype wire

/* bench/text_console_writer_top_test.sv */
`default_nettype none
module text_console_writer_top_test;
    import tcw_pkg::*;

    localparam int ROWS          = 25;
    localparam int COLUMNS       = 32;
    localparam int CELLS         = ROWS * COLUMNS;
    localparam int SETTLE_CYCLES = 2 * COLUMNS + 40;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 84;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] row;
        logic [4:0] col;
        logic [7:0] ch;
        logic [7:0] attr;
        logic       last;
    } console_cmd_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [3:0]  cfg_data  = '0;

    // Shadow copy of the screen, cursor and color registers.
    logic [7:0] char_cells [CELLS];
    logic [7:0] attr_cells [CELLS];
    int         cursor_col;
    logic [3:0] fg_color;
    logic [3:0] bg_color;
    logic       display_on;

    console_cmd_t expected_cmds [$];
    int           mismatch_count = 0;
    int           stall_cycles   = 0;
    int           hold_cycles    = 0;
    logic         idle_enabled   = 1'b1;

    text_console_writer_top #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [7:0] current_attr();
        return {bg_color, fg_color};
    endfunction

    task automatic queue_cmd(input logic [1:0] kind, input logic [4:0] row,
                             input logic [4:0] col, input logic [7:0] ch,
                             input logic [7:0] attr);
        console_cmd_t cmd;
        cmd = '{kind: kind, row: row, col: col, ch: ch, attr: attr, last: 1'b0};
        expected_cmds.push_back(cmd);
    endtask

    task automatic put_bottom_cell(input int col, input logic [7:0] ch);
        int idx;
        idx = (ROWS - 1) * COLUMNS + col;
        if (col < COLUMNS) begin
            char_cells[idx] = ch;
            attr_cells[idx] = current_attr();
            if (display_on) queue_cmd(KIND_SET, 5'(ROWS - 1), 5'(col), ch, current_attr());
        end
    endtask

    task automatic scroll_screen();
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
            char_cells[i] = char_cells[i + COLUMNS];
            attr_cells[i] = attr_cells[i + COLUMNS];
        end
        for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) begin
            char_cells[i] = 8'h00;
            attr_cells[i] = 8'h00;
        end
        if (display_on) queue_cmd(KIND_SCROLL, 5'd0, 5'd0, 8'h00, current_attr());
    endtask

    task automatic predict_console_item(input logic [1:0] op, input logic [7:0] ch,
                                        input logic [4:0] row, input logic [4:0] col);
        int           first;
        int           idx;
        console_cmd_t tail;
        first = expected_cmds.size();
        case (op)
            OP_WRITE: begin
                if (ch == CHAR_NEWLINE || ch == CHAR_RETURN) begin
                    while (cursor_col < COLUMNS) begin
                        put_bottom_cell(cursor_col, CHAR_SPACE);
                        cursor_col++;
                    end
                    scroll_screen();
                    cursor_col = 0;
                end else if (ch == CHAR_BACKSPACE) begin
                    if (cursor_col > 0) begin
                        cursor_col--;
                        put_bottom_cell(cursor_col, CHAR_SPACE);
                    end
                end else begin
                    put_bottom_cell(cursor_col, ch);
                    cursor_col++;
                    if (cursor_col >= COLUMNS) begin
                        scroll_screen();
                        cursor_col = 0;
                    end
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELLS; i++) begin
                    char_cells[i] = CHAR_SPACE;
                    attr_cells[i] = current_attr();
                end
                queue_cmd(KIND_CLEAR, 5'd0, 5'd0, 8'h00, current_attr());
            end
            OP_READ: begin
                if (row < ROWS && col < COLUMNS) begin
                    idx = row * COLUMNS + col;
                    queue_cmd(KIND_READ, row, col, char_cells[idx], attr_cells[idx]);
                end else begin
                    queue_cmd(KIND_READ, row, col, 8'h00, 8'h00);
                end
            end
            default: ;
        endcase
        if (expected_cmds.size() > first) begin
            tail = expected_cmds.pop_back();
            tail.last = 1'b1;
            expected_cmds.push_back(tail);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic check_console_cmd();
        console_cmd_t want;
        if (expected_cmds.size() == 0) begin
            report_mismatch("result with nothing expected, kind", m_tuser, 0);
        end else begin
            want = expected_cmds.pop_front();
            if (m_tuser != want.kind)        report_mismatch("command kind", m_tuser, want.kind);
            if (m_tdata[4:0] != want.row)    report_mismatch("row", m_tdata[4:0], want.row);
            if (m_tdata[9:5] != want.col)    report_mismatch("column", m_tdata[9:5], want.col);
            if (m_tdata[17:10] != want.ch)   report_mismatch("char", m_tdata[17:10], want.ch);
            if (m_tdata[25:18] != want.attr) report_mismatch("attribute", m_tdata[25:18], want.attr);
            if (m_tlast != want.last)        report_mismatch("tlast", m_tlast, want.last);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_console_cmd();
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            m_tready <= 1'b0;
        end else if (idle_enabled) begin
            m_tready <= ($urandom_range(99) >= 30);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("text_console_writer_top_test: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                             input logic [4:0] row, input logic [4:0] col);
        while (idle_enabled && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, col, row, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_console_item(op, ch, row, col);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [3:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (index)
            CFG_FG:     fg_color = value;
            CFG_BG:     bg_color = value;
            CFG_ACTIVE: display_on = value[0];
            default: ;
        endcase
    endtask

    // Writes that emit nothing may still be in progress once the queue is empty,
    // so a settling period follows before the registers are touched.
    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg, input logic active);
        wait_until_drained();
        write_reg(CFG_FG, fg);
        write_reg(CFG_BG, bg);
        write_reg(CFG_ACTIVE, {3'($urandom_range(7)), active});
    endtask

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            send_item(OP_WRITE, 8'($urandom_range(255)), 5'($urandom_range(31)), 5'($urandom_range(31)));
        else if (pick < 63)
            send_item(OP_WRITE, pick[0] ? CHAR_NEWLINE : CHAR_RETURN, 5'd0, 5'd0);
        else if (pick < 70)
            send_item(OP_WRITE, CHAR_BACKSPACE, 5'($urandom_range(31)), 5'($urandom_range(31)));
        else if (pick < 92)
            send_item(OP_READ, 8'($urandom_range(255)),
                      5'(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(ROWS - 1)),
                      5'($urandom_range(31)));
        else if (pick < 96)
            send_item(OP_CLEAR, 8'($urandom_range(255)), 5'($urandom_range(31)),
                      5'($urandom_range(31)));
        else
            send_item(OP_UNUSED, 8'($urandom_range(255)), 5'($urandom_range(31)),
                      5'($urandom_range(31)));
    endtask

    task automatic test_reset_state();
        send_item(OP_READ, 8'h00, 5'd24, 5'd0);
        send_item(OP_READ, 8'h00, 5'd0, 5'd31);
        send_item(OP_READ, 8'h00, 5'd12, 5'd17);
        send_item(OP_READ, 8'h00, 5'd25, 5'd0);
        send_item(OP_READ, 8'h00, 5'd31, 5'd31);
        send_item(OP_WRITE, 8'h41, 5'd0, 5'd0);
        send_item(OP_READ, 8'h00, 5'd24, 5'd0);
    endtask

    task automatic test_special_cases();
        set_colors(4'hf, 4'h0, 1'b1);
        send_item(OP_WRITE, CHAR_NEWLINE, 5'd0, 5'd0);
        send_item(OP_WRITE, CHAR_BACKSPACE, 5'd0, 5'd0);
        send_item(OP_WRITE, 8'h41, 5'd0, 5'd0);
        send_item(OP_WRITE, 8'h00, 5'd0, 5'd0);
        send_item(OP_WRITE, 8'hff, 5'd0, 5'd0);
        send_item(OP_WRITE, CHAR_BACKSPACE, 5'd0, 5'd0);
        send_item(OP_WRITE, CHAR_RETURN, 5'd0, 5'd0);
        send_item(OP_UNUSED, 8'hff, 5'd31, 5'd31);
        send_item(OP_READ, 8'h00, 5'd23, 5'd1);
        send_item(OP_READ, 8'h00, 5'd24, 5'd31);
        send_item(OP_CLEAR, 8'h00, 5'd0, 5'd0);
        send_item(OP_READ, 8'h00, 5'd24, 5'd31);
        send_item(OP_READ, 8'h00, 5'd0, 5'd0);
        set_colors(4'hf, 4'h0, 1'b0);
        send_item(OP_WRITE, 8'h78, 5'd0, 5'd0);
        send_item(OP_WRITE, CHAR_NEWLINE, 5'd0, 5'd0);
        send_item(OP_READ, 8'h00, 5'd23, 5'd0);
    endtask

    task automatic test_output_backpressure();
        set_colors(4'($urandom_range(15)), 4'($urandom_range(15)), 1'b1);
        hold_cycles = 400;
        for (int i = 0; i < 30; i++) begin
            if ($urandom_range(7) == 0)
                send_item(OP_WRITE, CHAR_NEWLINE, 5'd0, 5'd0);
            else
                send_item(OP_WRITE, 8'($urandom_range(126, 32)), 5'd0, 5'd0);
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_colors(4'h0, 4'h0, 1'b1);
                1: set_colors(4'hf, 4'hf, 1'b1);
                2: set_colors(4'($urandom_range(15)), 4'($urandom_range(15)), 1'b0);
                3: set_colors(4'($urandom_range(15)), 4'($urandom_range(15)), 1'b1);
                default: set_colors(4'h5, 4'ha, 1'b1);
            endcase
            idle_enabled = (phase != 1);
            for (int i = 0; i < PHASE_ITEMS; i++) send_random_item();
            idle_enabled = 1'b1;
        end
    endtask

    initial begin
        for (int i = 0; i < CELLS; i++) begin
            char_cells[i] = CHAR_SPACE;
            attr_cells[i] = 8'h00;
        end
        cursor_col = 0;
        fg_color   = FG_RESET;
        bg_color   = BG_RESET;
        display_on = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_special_cases();
        test_output_backpressure();
        test_random_traffic();

        wait_until_drained();
        if (mismatch_count == 0) begin
            $display("text_console_writer_top_test: clean");
        end else begin
            $display("text_console_writer_top_test: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
